/* hw/rtl/crcfr_pkg.sv */
// Shared types, constants and CRC helpers of the CRC-16 frame receiver.
// No dependencies; every other file of the block but crcfr_if imports this package.
package crcfr_pkg;

	localparam int unsigned TYPE_OFFSET      = 5;
	localparam int unsigned CRC_START_OFFSET = 2;
	localparam int unsigned FRAME_OVERHEAD   = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Configuration register indexes
	localparam logic REG_SOF_BYTE    = 1'b0;
	localparam logic REG_FRAME_LIMIT = 1'b1;

	localparam logic [7:0] SOF_BYTE_RST    = 8'd104;
	localparam logic [8:0] FRAME_LIMIT_RST = 9'd256;

	// Result status codes
	localparam logic [1:0] ST_IN_FRAME = 2'd0;
	localparam logic [1:0] ST_CRC_GOOD = 2'd1;
	localparam logic [1:0] ST_CRC_BAD  = 2'd2;
	localparam logic [1:0] ST_OVERSIZE = 2'd3;

	// Role of one frame byte, decided by the front end
	typedef enum logic [2:0] {
		K_START,
		K_LEN,
		K_OVER,
		K_DATA,
		K_CRC_LO,
		K_LAST
	} byte_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [8:0] byte_index;
		byte_kind_t kind;
		logic       type_en;
		logic [8:0] frame_length;
	} crcfr_entry_t;

	// Nibble table of the reflected 0xA001 polynomial
	function automatic logic [15:0] nib_tab(input logic [3:0] n);
		logic [15:0] v;
		case (n)
			4'h0: v = 16'h0000;
			4'h1: v = 16'hCC01;
			4'h2: v = 16'hD801;
			4'h3: v = 16'h1400;
			4'h4: v = 16'hF001;
			4'h5: v = 16'h3C00;
			4'h6: v = 16'h2800;
			4'h7: v = 16'hE401;
			4'h8: v = 16'hA001;
			4'h9: v = 16'h6C00;
			4'hA: v = 16'h7800;
			4'hB: v = 16'hB401;
			4'hC: v = 16'h5000;
			4'hD: v = 16'h9C01;
			4'hE: v = 16'h8801;
			4'hF: v = 16'h4400;
			default: v = 16'h0000;
		endcase
		return v;
	endfunction

	// Advance CRC-16/MODBUS by one byte, low nibble first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] t;
		t = nib_tab(b[3:0] ^ c[3:0]) ^ (c >> 4);
		t = nib_tab(b[7:4] ^ t[3:0]) ^ (t >> 4);
		return t;
	endfunction

endpackage

/* hw/rtl/crcfr_if.sv */
// Request channel interfaces of the CRC-16 frame receiver.
// Depends on nothing; used by the top level, the back end and the bench.
interface crcfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [8:0] byte_index;
	logic       frame_end;
	logic [1:0] status;
	logic [7:0] frame_type;
	logic [8:0] frame_length;

	modport source (output valid, output data_byte, output byte_index, output frame_end,
		output status, output frame_type, output frame_length, input ready);
	modport sink   (input valid, input data_byte, input byte_index, input frame_end,
		input status, input frame_type, input frame_length, output ready);
endinterface

/* hw/rtl/crcfr_front.sv */
// Front end: holds the configuration registers, tracks the frame phase and
// tags each accepted byte with its role. Depends on crcfr_pkg.
module crcfr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [8:0]             cfg_data,
	input  logic                   accept,
	input  logic [7:0]             rx_byte,
	output logic                   push,
	output crcfr_pkg::crcfr_entry_t push_entry
);
	import crcfr_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t     phase_q;
	logic [8:0] count_q;
	logic [7:0] len_q;
	logic [7:0] sof_byte_q;
	logic [8:0] frame_limit_q;

	logic [8:0] len_total;
	logic [8:0] body_total;
	logic       oversize;

	assign len_total  = {1'b0, rx_byte} + 9'(FRAME_OVERHEAD);
	assign body_total = {1'b0, len_q} + 9'(FRAME_OVERHEAD);
	assign oversize   = len_total > frame_limit_q;

	// Classify the incoming byte
	always_comb begin
		push                    = 1'b0;
		push_entry.data_byte    = rx_byte;
		push_entry.byte_index   = count_q;
		push_entry.kind         = K_DATA;
		push_entry.type_en      = 1'b0;
		push_entry.frame_length = body_total;
		case (phase_q)
			PH_HUNT: begin
				push                  = accept && (rx_byte == sof_byte_q);
				push_entry.kind       = K_START;
				push_entry.byte_index = 9'd0;
			end
			PH_LEN: begin
				push                    = accept;
				push_entry.kind         = oversize ? K_OVER : K_LEN;
				push_entry.byte_index   = 9'd1;
				push_entry.frame_length = len_total;
			end
			PH_BODY: begin
				push               = accept;
				push_entry.type_en = (count_q == 9'(TYPE_OFFSET));
				if (count_q + 9'd1 >= body_total) begin
					push_entry.kind = K_LAST;
				end else if (count_q == {1'b0, len_q} + 9'd2) begin
					push_entry.kind = K_CRC_LO;
				end else begin
					push_entry.kind = K_DATA;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_byte_q    <= SOF_BYTE_RST;
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOF_BYTE:    sof_byte_q    <= cfg_data[7:0];
				REG_FRAME_LIMIT: frame_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the frame phase on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 9'd0;
			len_q   <= 8'd0;
		end else if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == sof_byte_q) begin
						phase_q <= PH_LEN;
						count_q <= 9'd1;
						len_q   <= 8'd0;
					end
				end
				PH_LEN: begin
					if (oversize) begin
						phase_q <= PH_HUNT;
						count_q <= 9'd0;
					end else begin
						phase_q <= PH_BODY;
						count_q <= 9'(CRC_START_OFFSET);
						len_q   <= rx_byte;
					end
				end
				PH_BODY: begin
					if (count_q + 9'd1 >= body_total) begin
						phase_q <= PH_HUNT;
						count_q <= 9'd0;
					end else begin
						count_q <= count_q + 9'd1;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					count_q <= 9'd0;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/crcfr_queue.sv */
// Two-entry queue between the front end and the back end.
// Depends on crcfr_pkg for the entry type.
module crcfr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcfr_pkg::crcfr_entry_t push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    head_valid,
	output crcfr_pkg::crcfr_entry_t head_entry
);
	import crcfr_pkg::*;

	crcfr_entry_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

/* hw/rtl/crcfr_back.sv */
// Back end: runs the CRC, holds the type and CRC low byte, and drives the
// registered result channel. Depends on crcfr_pkg and crcfr_result_if.
module crcfr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  crcfr_pkg::crcfr_entry_t head_entry,
	output logic                    pop,
	crcfr_result_if.source          result
);
	import crcfr_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  type_q;
	logic [7:0]  crc_lo_q;
	logic        out_valid_q;

	logic [7:0]  type_eff;
	logic        crc_match;

	assign pop          = head_valid && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign type_eff     = head_entry.type_en ? head_entry.data_byte : type_q;
	assign crc_match    = ({head_entry.data_byte, crc_lo_q} == crc_q);

	// Hold valid of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Update frame state and load the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			result.data_byte    <= head_entry.data_byte;
			result.byte_index   <= head_entry.byte_index;
			result.frame_end    <= 1'b0;
			result.status       <= ST_IN_FRAME;
			result.frame_type   <= 8'd0;
			result.frame_length <= 9'd0;
			if (head_entry.type_en) begin
				type_q <= head_entry.data_byte;
			end
			case (head_entry.kind)
				K_START: begin
					crc_q    <= CRC_INIT;
					type_q   <= 8'd0;
					crc_lo_q <= 8'd0;
				end
				K_LEN: ;
				K_OVER: begin
					result.frame_end    <= 1'b1;
					result.status       <= ST_OVERSIZE;
					result.frame_length <= head_entry.frame_length;
				end
				K_DATA: begin
					crc_q <= crc_byte(crc_q, head_entry.data_byte);
				end
				K_CRC_LO: begin
					crc_lo_q <= head_entry.data_byte;
				end
				K_LAST: begin
					result.frame_end    <= 1'b1;
					result.status       <= crc_match ? ST_CRC_GOOD : ST_CRC_BAD;
					result.frame_type   <= type_eff;
					result.frame_length <= head_entry.frame_length;
				end
				default: ;
			endcase
		end
	end

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped entry not loaded into result register");
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result.frame_end |-> result.status != ST_IN_FRAME)
		else $error("frame end without final status");
	a_over_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result.status == ST_OVERSIZE |->
			result.byte_index == 9'd1 && result.frame_type == 8'd0)
		else $error("oversize result on wrong byte");

endmodule

/* hw/rtl/crc16_frame_receiver.sv */
// CRC-16/MODBUS length-prefixed frame receiver, top level.
// Depends on crcfr_pkg, crcfr_if, crcfr_front, crcfr_queue and crcfr_back.
//
// Usage:
//   rx carries one received byte per request. While hunting, bytes other than
//   the start code are taken and dropped. A start code opens a frame; the next
//   byte is the body length L and the frame is L+4 bytes. Every frame byte
//   comes out on result with its index; the last byte carries frame_end, the
//   CRC status, the type byte and the total length. A length whose frame would
//   exceed frame_limit ends the frame at once with the oversize status.
//   The cfg port writes the start-of-frame byte (index 0) and frame_limit
//   (index 1); write it only while no byte is in flight.
// Timing:
//   One byte per cycle sustained while result is ready. A taken byte passes
//   through the two-entry queue and then the result register. While result
//   is ready, the CRC advances one byte per cycle via two nibble table lookups.
// Reset and stall:
//   Reset returns to hunting, start code 104 and frame_limit 256, queue empty.
//   When result stalls, the queue absorbs two bytes and then rx.ready drops
//   until the result register is taken.
module crc16_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	crcfr_byte_if.sink     rx,
	crcfr_result_if.source result
);
	import crcfr_pkg::*;

	logic         accept;
	logic         push;
	logic         full;
	logic         pop;
	logic         head_valid;
	crcfr_entry_t push_entry;
	crcfr_entry_t head_entry;

	// Take a byte whenever the queue has room
	assign rx.ready = !full;
	assign accept   = rx.valid && !full;

	crcfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.rx_byte    (rx.rx_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	crcfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	crcfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* dv/crc16_frame_receiver_tb.sv */
// Self-checking bench for the CRC-16 frame receiver: random byte streams in, every
// passed-through byte and frame end predicted here and checked in order.
// Depends on crcfr_pkg, crcfr_if and crc16_frame_receiver.
module crc16_frame_receiver_tb;
	import crcfr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 40;

	typedef enum logic [1:0] {
		RX_HUNT,
		RX_LEN,
		RX_BODY
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [8:0] byte_index;
		logic       frame_end;
		logic [1:0] status;
		logic [7:0] frame_type;
		logic [8:0] frame_length;
	} frame_result_t;

	typedef struct {
		logic [7:0] value;
		bit         drain_first;
	} tx_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = REG_SOF_BYTE;
	logic [8:0] cfg_data = '0;

	crcfr_byte_if   rx_ch();
	crcfr_result_if res_ch();

	crc16_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.result    (res_ch)
	);

	// Register copies, kept in step with every write
	logic [7:0] cfg_start = SOF_BYTE_RST;
	logic [8:0] cfg_limit = FRAME_LIMIT_RST;

	// Receiver state as predicted
	rx_phase_t   rcv_phase = RX_HUNT;
	int          rcv_count = 0;
	int          rcv_body_len = 0;
	logic [15:0] rcv_crc = CRC_INIT;
	logic [7:0]  rcv_type = '0;
	logic [7:0]  rcv_crc_lo = '0;

	tx_byte_t      tx_bytes[$];
	frame_result_t results_due[$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_dropped = 0;
	int n_good = 0;
	int n_bad = 0;
	int n_over = 0;

	// Driver pacing
	int gap_left = 0;
	int burst_left = 8;
	bit took;

	// Receiver stall pattern
	int stall_mode = 0;
	int mode_left = 64;
	bit ready_next;

	always #1 clk = ~clk;

	// CRC-16/MODBUS, one byte, bit by bit
	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
	endtask

	// Advance the predicted receiver by one accepted byte and queue what it reports
	task automatic track_byte(input logic [7:0] b);
		frame_result_t r;
		int            idx;
		int            total;
		logic [15:0]   got_crc;
		r = '0;
		r.data_byte = b;
		case (rcv_phase)
			RX_HUNT: begin
				if (b != cfg_start) begin
					n_dropped++;
					return;
				end
				rcv_phase = RX_LEN;
				rcv_count = 1;
				rcv_body_len = 0;
				rcv_crc = CRC_INIT;
				rcv_type = '0;
				rcv_crc_lo = '0;
				r.byte_index = 9'd0;
				r.status = ST_IN_FRAME;
			end
			RX_LEN: begin
				total = int'(b) + FRAME_OVERHEAD;
				r.byte_index = 9'd1;
				if (total > int'(cfg_limit)) begin
					rcv_phase = RX_HUNT;
					rcv_count = 0;
					r.frame_end = 1'b1;
					r.status = ST_OVERSIZE;
					r.frame_length = 9'(total);
				end else begin
					rcv_body_len = int'(b);
					rcv_count = 2;
					rcv_phase = RX_BODY;
					if (TYPE_OFFSET == 1)
						rcv_type = b;
					r.status = ST_IN_FRAME;
				end
			end
			default: begin
				idx = rcv_count;
				total = rcv_body_len + FRAME_OVERHEAD;
				if (idx == TYPE_OFFSET)
					rcv_type = b;
				if (idx >= CRC_START_OFFSET && idx < rcv_body_len + 2)
					rcv_crc = crc16_modbus_step(rcv_crc, b);
				else if (idx == rcv_body_len + 2)
					rcv_crc_lo = b;
				r.byte_index = 9'(idx);
				if (idx + 1 >= total) begin
					got_crc = {b, rcv_crc_lo};
					rcv_phase = RX_HUNT;
					rcv_count = 0;
					r.frame_end = 1'b1;
					r.status = (got_crc == rcv_crc) ? ST_CRC_GOOD : ST_CRC_BAD;
					r.frame_type = rcv_type;
					r.frame_length = 9'(total);
				end else begin
					rcv_count = idx + 1;
					r.status = ST_IN_FRAME;
				end
			end
		endcase
		results_due.push_back(r);
	endtask

	task automatic check_result();
		frame_result_t want;
		n_checked++;
		if (results_due.size() == 0) begin
			report_mismatch("result with no byte pending, data_byte", res_ch.data_byte, -1);
			return;
		end
		want = results_due.pop_front();
		if (res_ch.data_byte !== want.data_byte)
			report_mismatch("data_byte", res_ch.data_byte, want.data_byte);
		if (res_ch.byte_index !== want.byte_index)
			report_mismatch("byte_index", res_ch.byte_index, want.byte_index);
		if (res_ch.frame_end !== want.frame_end)
			report_mismatch("frame_end", res_ch.frame_end, want.frame_end);
		if (res_ch.status !== want.status)
			report_mismatch("status", res_ch.status, want.status);
		if (res_ch.frame_type !== want.frame_type)
			report_mismatch("frame_type", res_ch.frame_type, want.frame_type);
		if (res_ch.frame_length !== want.frame_length)
			report_mismatch("frame_length", res_ch.frame_length, want.frame_length);
		if (want.frame_end) begin
			case (want.status)
				ST_CRC_GOOD: n_good++;
				ST_CRC_BAD:  n_bad++;
				default:     n_over++;
			endcase
		end
	endtask

	task automatic push_byte(input logic [7:0] value, input bit drain);
		tx_byte_t t;
		t.value = value;
		t.drain_first = drain;
		tx_bytes.push_back(t);
	endtask

	// Queue one frame; an oversize length stops after the length byte
	task automatic add_frame(input int len, input bit bad_crc, input bit drain, input bit all_start);
		logic [15:0] crc;
		logic [7:0]  body_byte;
		crc = CRC_INIT;
		push_byte(cfg_start, drain);
		push_byte(8'(len), 1'b0);
		if (len + FRAME_OVERHEAD <= int'(cfg_limit)) begin
			for (int i = 0; i < len; i++) begin
				body_byte = (all_start || $urandom_range(0, 7) == 0) ? cfg_start : 8'($urandom);
				crc = crc16_modbus_step(crc, body_byte);
				push_byte(body_byte, 1'b0);
			end
			if (bad_crc)
				crc ^= 16'(32'd1 << $urandom_range(0, 15));
			push_byte(crc[7:0], 1'b0);
			push_byte(crc[15:8], 1'b0);
		end
	endtask

	// Mostly short bodies, some empty, a few right at the length limit
	function automatic int pick_body_len();
		int r;
		int near;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 75)
			return $urandom_range(1, 12);
		if (r < 92)
			return $urandom_range(13, 40);
		if (int'(cfg_limit) > 44)
			near = int'(cfg_limit) - 3 + int'($urandom_range(0, 1));
		else
			near = int'(cfg_limit) - 5 + int'($urandom_range(0, 2));
		if (near > 255)
			near = $urandom_range(0, 12);
		if (near < 0)
			near = 0;
		return near;
	endfunction

	// Well-formed frames with random content, plus noise and broken frames
	task automatic add_random_traffic(input int budget);
		int used;
		int pick;
		int n;
		int was;
		used = 0;
		while (used < budget) begin
			pick = $urandom_range(0, 99);
			was = tx_bytes.size();
			if (pick < 12) begin
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom), 1'b0);
			end else if (pick < 22) begin
				n = $urandom_range(0, 5);
				push_byte(cfg_start, 1'b0);
				push_byte(8'($urandom), 1'b0);
				repeat (n)
					push_byte(8'($urandom), 1'b0);
				used += tx_bytes.size() - was;
			end else begin
				add_frame(pick_body_len(), $urandom_range(0, 4) == 0,
					$urandom_range(0, 39) == 0, 1'b0);
				used += tx_bytes.size() - was;
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOF_BYTE)
			cfg_start = value[7:0];
		else
			cfg_limit = value;
	endtask

	// Hold until every queued byte is taken and every result is back
	task automatic wait_idle();
		while (tx_bytes.size() != 0 || rx_ch.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Count cycles; stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, results_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Byte driver: present queued bytes in bursts, hold each until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else begin
			took = rx_ch.valid && rx_ch.ready;
			if (took) begin
				track_byte(rx_ch.rx_byte);
				void'(tx_bytes.pop_front());
				n_sent++;
			end
			if (!rx_ch.valid || took) begin
				if (gap_left != 0) begin
					gap_left--;
					rx_ch.valid <= 1'b0;
				end else if (tx_bytes.size() == 0 ||
					(tx_bytes[0].drain_first && results_due.size() != 0)) begin
					rx_ch.valid <= 1'b0;
				end else begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= tx_bytes[0].value;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Result monitor: check each taken result, stall on a changing pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_result();
			case (stall_mode)
				0:       ready_next = 1'b1;
				1:       ready_next = (cycle_count % 4) != 3;
				2:       ready_next = $urandom_range(0, 1);
				default: ready_next = (cycle_count % 16) < 4;
			endcase
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 256);
			end else begin
				mode_left--;
			end
			res_ch.ready <= ready_next;
		end
	end

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: noise, empty body, start codes in the body,
		// short bad frame, type on a CRC byte, oversize length
		@(negedge clk);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(SOF_BYTE_RST - 8'd1, 1'b0);
		push_byte(SOF_BYTE_RST + 8'd1, 1'b0);
		add_frame(0, 1'b0, 1'b0, 1'b0);
		add_frame(2, 1'b0, 1'b0, 1'b1);
		add_frame(1, 1'b1, 1'b0, 1'b0);
		add_frame(3, 1'b0, 1'b0, 1'b0);
		add_frame(255, 1'b0, 1'b0, 1'b0);
		add_random_traffic(140);
		wait_idle();

		// Lowest start code, limit under four: every frame oversize
		write_reg(REG_SOF_BYTE, 9'd0);
		write_reg(REG_FRAME_LIMIT, 9'd3);
		@(negedge clk);
		add_frame(0, 1'b0, 1'b0, 1'b0);
		add_random_traffic(100);
		wait_idle();

		// Highest start code, limit four: only empty bodies fit
		write_reg(REG_SOF_BYTE, 9'd255);
		write_reg(REG_FRAME_LIMIT, 9'd4);
		@(negedge clk);
		add_frame(0, 1'b0, 1'b0, 1'b0);
		add_frame(1, 1'b0, 1'b0, 1'b0);
		add_random_traffic(100);
		wait_idle();

		// Limit 259, the largest frame size, with one full-size frame
		write_reg(REG_SOF_BYTE, 9'($urandom_range(0, 255)));
		write_reg(REG_FRAME_LIMIT, 9'd259);
		@(negedge clk);
		add_frame(255, 1'b0, 1'b0, 1'b0);
		add_random_traffic(120);
		wait_idle();

		// Small random limit; stop mid-stream until all results are back
		write_reg(REG_SOF_BYTE, 9'(SOF_BYTE_RST));
		write_reg(REG_FRAME_LIMIT, 9'($urandom_range(4, 40)));
		@(negedge clk);
		add_random_traffic(70);
		add_frame(pick_body_len(), 1'b0, 1'b1, 1'b0);
		add_random_traffic(70);
		wait_idle();

		$display("Sent %0d bytes (%0d dropped while hunting) under five register settings",
			n_sent, n_dropped);
		$display("Checked %0d results: %0d good CRC, %0d bad CRC, %0d oversize lengths",
			n_checked, n_good, n_bad, n_over);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_if.sv
hw/rtl/crcfr_front.sv
hw/rtl/crcfr_queue.sv
hw/rtl/crcfr_back.sv
hw/rtl/crc16_frame_receiver.sv
dv/crc16_frame_receiver_tb.sv
